FILE: rtl/lje_pkg.sv
// ----------------------------------------------------------------------------
// lje_pkg
// Shared types, constants and the microcode table of the LCG jump-ahead and
// index engine.
// ----------------------------------------------------------------------------
package lje_pkg;

  // Fixed field widths
  localparam int DATA_W  = 64;  // seed, steps, value and register words
  localparam int STEPS_W = 64;  // jump count
  localparam int RND_W   = 6;   // round counter, up to 64 rounds
  localparam int PC_W    = 4;   // microcode address
  localparam int CFG_AW  = 4;   // config register index

  // Config register indexes
  localparam logic [CFG_AW-1:0] REG_MULT  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_INC   = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_IMULT = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_IINC  = CFG_AW'(3);

  // Command codes
  typedef enum logic [1:0] {
    CMD_FWD  = 2'd0,
    CMD_BWD  = 2'd1,
    CMD_IDX  = 2'd2,
    CMD_PASS = 2'd3
  } cmd_e;

  // Micro-operations
  typedef enum logic [2:0] {
    UOP_SKIPZ = 3'd0,  // branch to tgt when test bit is clear
    UOP_MUL   = 3'd1,  // multiply on shared unit, write back to dst
    UOP_SUB   = 3'd2,  // x -= c, set current bit of n
    UOP_LOOP  = 3'd3,  // end of round; branch to tgt unless last
    UOP_DONE  = 3'd4   // emit result, go idle
  } uop_e;

  typedef enum logic [1:0] {OPA_X = 2'd0, OPA_M = 2'd1, OPA_C = 2'd2} opa_e;
  typedef enum logic [1:0] {OPB_M = 2'd0, OPB_C = 2'd1, OPB_M1 = 2'd2} opb_e;
  typedef enum logic [1:0] {DST_X = 2'd0, DST_C = 2'd1, DST_M = 2'd2} dst_e;
  typedef enum logic {TST_STEPS = 1'b0, TST_XBIT = 1'b1} tst_e;
  typedef enum logic {LIM_JUMP = 1'b0, LIM_WIDTH = 1'b1} lim_e;
  typedef enum logic {OUT_X = 1'b0, OUT_N = 1'b1} out_e;

  // One control word
  typedef struct packed {
    uop_e            uop;
    opa_e            opa;
    opb_e            opb;
    dst_e            dst;
    logic            addc;
    tst_e            tst;
    lim_e            lim;
    out_e            outsel;
    logic [PC_W-1:0] tgt;
  } ucw_t;

  // Sequencer to datapath
  typedef struct packed {
    logic act;
    ucw_t cw;
  } ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic test;
    logic last;
    logic mul_done;
  } stat_t;

  // Program labels
  localparam logic [PC_W-1:0] UPC_J_TOP  = PC_W'(0);
  localparam logic [PC_W-1:0] UPC_J_CUPD = PC_W'(2);
  localparam logic [PC_W-1:0] UPC_J_END  = PC_W'(5);
  localparam logic [PC_W-1:0] UPC_L_TOP  = PC_W'(6);
  localparam logic [PC_W-1:0] UPC_L_CUPD = PC_W'(9);

  function automatic ucw_t mk(input uop_e u, input opa_e a, input opb_e b,
                              input dst_e d, input logic ac, input tst_e t,
                              input lim_e l, input out_e o,
                              input logic [PC_W-1:0] g);
    ucw_t w;
    w.uop    = u;
    w.opa    = a;
    w.opb    = b;
    w.dst    = d;
    w.addc   = ac;
    w.tst    = t;
    w.lim    = l;
    w.outsel = o;
    w.tgt    = g;
    return w;
  endfunction

  // Microcode ROM
  //   jump:   per round: x = x*m + c if count bit set; c = m*c + c; m = m*m
  //   locate: per round: if x bit set {x -= c; n |= bit; c = c*m};
  //           c = c*(m+1); m = m*m
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = mk(UOP_DONE, OPA_X, OPB_M, DST_X, 1'b0, TST_STEPS, LIM_JUMP, OUT_X, '0);
    unique case (pc)
      PC_W'(0):  w = mk(UOP_SKIPZ, OPA_X, OPB_M, DST_X, 1'b0, TST_STEPS, LIM_JUMP,
                        OUT_X, UPC_J_CUPD);
      PC_W'(1):  w = mk(UOP_MUL, OPA_X, OPB_M, DST_X, 1'b1, TST_STEPS, LIM_JUMP,
                        OUT_X, '0);
      PC_W'(2):  w = mk(UOP_MUL, OPA_M, OPB_C, DST_C, 1'b1, TST_STEPS, LIM_JUMP,
                        OUT_X, '0);
      PC_W'(3):  w = mk(UOP_MUL, OPA_M, OPB_M, DST_M, 1'b0, TST_STEPS, LIM_JUMP,
                        OUT_X, '0);
      PC_W'(4):  w = mk(UOP_LOOP, OPA_X, OPB_M, DST_X, 1'b0, TST_STEPS, LIM_JUMP,
                        OUT_X, UPC_J_TOP);
      PC_W'(5):  w = mk(UOP_DONE, OPA_X, OPB_M, DST_X, 1'b0, TST_STEPS, LIM_JUMP,
                        OUT_X, '0);
      PC_W'(6):  w = mk(UOP_SKIPZ, OPA_X, OPB_M, DST_X, 1'b0, TST_XBIT, LIM_WIDTH,
                        OUT_N, UPC_L_CUPD);
      PC_W'(7):  w = mk(UOP_SUB, OPA_X, OPB_M, DST_X, 1'b0, TST_XBIT, LIM_WIDTH,
                        OUT_N, '0);
      PC_W'(8):  w = mk(UOP_MUL, OPA_C, OPB_M, DST_C, 1'b0, TST_XBIT, LIM_WIDTH,
                        OUT_N, '0);
      PC_W'(9):  w = mk(UOP_MUL, OPA_C, OPB_M1, DST_C, 1'b0, TST_XBIT, LIM_WIDTH,
                        OUT_N, '0);
      PC_W'(10): w = mk(UOP_MUL, OPA_M, OPB_M, DST_M, 1'b0, TST_XBIT, LIM_WIDTH,
                        OUT_N, '0);
      PC_W'(11): w = mk(UOP_LOOP, OPA_X, OPB_M, DST_X, 1'b0, TST_XBIT, LIM_WIDTH,
                        OUT_N, UPC_L_TOP);
      PC_W'(12): w = mk(UOP_DONE, OPA_X, OPB_M, DST_X, 1'b0, TST_XBIT, LIM_WIDTH,
                        OUT_N, '0);
      default:   w = mk(UOP_DONE, OPA_X, OPB_M, DST_X, 1'b0, TST_STEPS, LIM_JUMP,
                        OUT_X, '0);
    endcase
    return w;
  endfunction

  // Program entry per command
  function automatic logic [PC_W-1:0] entry(input logic [1:0] cmd);
    logic [PC_W-1:0] pc;
    unique case (cmd)
      CMD_FWD, CMD_BWD: pc = UPC_J_TOP;
      CMD_IDX:          pc = UPC_L_TOP;
      default:          pc = UPC_J_END;  // pass-through
    endcase
    return pc;
  endfunction

endpackage

FILE: rtl/lje_mul.sv
// ----------------------------------------------------------------------------
// lje_mul
// Multi-cycle modular multiplier: low WIDTH bits of a*b from three
// half-width partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module lje_mul #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             done_o,
  output logic [WIDTH-1:0] p_o
);

  localparam int LW = (WIDTH + 1) / 2;
  localparam int PW = 2 * LW;

  logic [1:0]       phase_q, phase_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [LW-1:0]    a_lo, a_hi, b_lo, b_hi;
  logic [LW-1:0]    mx, my;
  logic [PW-1:0]    prod;

  // operand halves, high halves zero-extended
  assign a_lo = a_i[LW-1:0];
  assign b_lo = b_i[LW-1:0];
  assign a_hi = LW'(a_i[WIDTH-1:LW]);
  assign b_hi = LW'(b_i[WIDTH-1:LW]);

  // partial product select
  always_comb begin
    case (phase_q)
      2'd1:    begin mx = a_lo; my = b_hi; end
      2'd2:    begin mx = a_hi; my = b_lo; end
      default: begin mx = a_lo; my = b_lo; end
    endcase
  end

  assign prod = PW'(mx) * PW'(my);

  // accumulate: lo*lo, then cross terms shifted up by LW
  always_comb begin
    acc_d = acc_q;
    case (phase_q)
      2'd0:    acc_d = WIDTH'(prod);
      2'd1,
      2'd2:    acc_d = acc_q + (WIDTH'(prod) << LW);
      default: acc_d = acc_q;
    endcase
  end

  assign phase_d = (go_i && phase_q != 2'd3) ? phase_q + 2'd1 : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = go_i && (phase_q == 2'd3);
  assign p_o    = acc_q;

endmodule

FILE: rtl/lje_seq.sv
// ----------------------------------------------------------------------------
// lje_seq
// Microcode sequencer: step counter, ROM fetch and conditional branches.
// ----------------------------------------------------------------------------
module lje_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           cmd_i,
  input  lje_pkg::stat_t       stat_i,
  output lje_pkg::ctl_t        ctl_o,
  output logic                 busy_o
);

  logic [lje_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     busy_q, busy_d;
  lje_pkg::ucw_t            cw;

  assign cw = lje_pkg::ucode(pc_q);

  // next step
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (busy_q) begin
      unique case (cw.uop)
        lje_pkg::UOP_SKIPZ: pc_d = stat_i.test ? pc_q + 1'b1 : cw.tgt;
        lje_pkg::UOP_MUL: begin
          if (stat_i.mul_done) begin
            pc_d = pc_q + 1'b1;
          end
        end
        lje_pkg::UOP_SUB:   pc_d = pc_q + 1'b1;
        lje_pkg::UOP_LOOP:  pc_d = stat_i.last ? pc_q + 1'b1 : cw.tgt;
        default:            busy_d = 1'b0;  // done
      endcase
    end else if (start_i) begin
      pc_d   = lje_pkg::entry(cmd_i);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign ctl_o.act = busy_q;
  assign ctl_o.cw  = cw;
  assign busy_o    = busy_q;

endmodule

FILE: rtl/lje_dp.sv
// ----------------------------------------------------------------------------
// lje_dp
// Datapath: state x, multiplier m, increment c, index n, round counter and
// shared multiplier, driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module lje_dp #(
  parameter int WIDTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [1:0]                  cmd_i,
  input  logic [WIDTH-1:0]            seed_i,
  input  logic [lje_pkg::STEPS_W-1:0] steps_i,
  input  logic [WIDTH-1:0]            mult_i,
  input  logic [WIDTH-1:0]            inc_i,
  input  logic [WIDTH-1:0]            imult_i,
  input  logic [WIDTH-1:0]            iinc_i,
  input  lje_pkg::ctl_t               ctl_i,
  output lje_pkg::stat_t              stat_o,
  output logic                        done_o,
  output logic [lje_pkg::DATA_W-1:0]  value_o
);

  logic [WIDTH-1:0]                  x_q, m_q, c_q, n_q, bit_q;
  logic [lje_pkg::STEPS_W-1:0]       steps_q;
  logic [lje_pkg::RND_W-1:0]         rnd_q;
  logic [lje_pkg::DATA_W-1:0]        value_q;
  logic                              done_q;
  lje_pkg::ucw_t                     cw;
  logic                              mul_go, mul_done;
  logic [WIDTH-1:0]                  opa, opb, mul_p, wb;
  logic                              last_jump;

  assign cw     = ctl_i.cw;
  assign mul_go = ctl_i.act && (cw.uop == lje_pkg::UOP_MUL);

  // operand select
  always_comb begin
    case (cw.opa)
      lje_pkg::OPA_M: opa = m_q;
      lje_pkg::OPA_C: opa = c_q;
      default:        opa = x_q;
    endcase
    case (cw.opb)
      lje_pkg::OPB_C:  opb = c_q;
      lje_pkg::OPB_M1: opb = m_q + WIDTH'(1);
      default:         opb = m_q;
    endcase
  end

  lje_mul #(.WIDTH(WIDTH)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (opa),
    .b_i    (opb),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign wb = mul_p + (cw.addc ? c_q : '0);

  // branch conditions; a jump ends early once no count bits remain
  assign last_jump = (rnd_q == '1) || (steps_q[lje_pkg::STEPS_W-1:1] == '0);

  assign stat_o.test     = (cw.tst == lje_pkg::TST_XBIT) ? |(x_q & bit_q) : steps_q[0];
  assign stat_o.last     = (cw.lim == lje_pkg::LIM_WIDTH) ?
                           (rnd_q == lje_pkg::RND_W'(WIDTH - 1)) : last_jump;
  assign stat_o.mul_done = mul_done;

  // working registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q     <= seed_i;
      m_q     <= (cmd_i == lje_pkg::CMD_BWD) ? imult_i : mult_i;
      c_q     <= (cmd_i == lje_pkg::CMD_BWD) ? iinc_i : inc_i;
      steps_q <= steps_i;
      n_q     <= '0;
      bit_q   <= WIDTH'(1);
      rnd_q   <= '0;
    end else if (ctl_i.act) begin
      case (cw.uop)
        lje_pkg::UOP_MUL: begin
          if (mul_done) begin
            case (cw.dst)
              lje_pkg::DST_C: c_q <= wb;
              lje_pkg::DST_M: m_q <= wb;
              default:        x_q <= wb;
            endcase
          end
        end
        lje_pkg::UOP_SUB: begin
          x_q <= x_q - c_q;
          n_q <= n_q | bit_q;
        end
        lje_pkg::UOP_LOOP: begin
          rnd_q   <= rnd_q + 1'b1;
          steps_q <= steps_q >> 1;
          bit_q   <= bit_q << 1;
        end
        lje_pkg::UOP_DONE: begin
          value_q <= lje_pkg::DATA_W'((cw.outsel == lje_pkg::OUT_N) ? n_q : x_q);
        end
        default: ;
      endcase
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.act && (cw.uop == lje_pkg::UOP_DONE);
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

FILE: rtl/lcg_jump_and_index_engine.sv
// ----------------------------------------------------------------------------
// lcg_jump_and_index_engine
// Jump-ahead, jump-back and step-index engine for an LCG modulo 2^WIDTH,
// run by a microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | flow
//  ---------+------------------------------------------+-----------------------
//  command  | start, busy, cmd_i, seed_i, steps_i      | taken when start & !busy
//  result   | done_o, value_o                          | one-cycle strobe
//  config   | cfg_valid_i, cfg_ready_o, cfg_addr_i,    | taken when valid & ready
//           | cfg_data_i                               |
//
// Each multiply runs on the shared 32x32 multiplier.
// Jump: each round updates c and m, and x too when the count bit is set; rounds
// stop after the highest set bit of steps (one round for a zero count, at most 64).
// Index: WIDTH rounds.
// The result strobe comes in the cycle after the final step; busy drops with it.
// Reset restores the registers to multiplier 1, increment 0, inverses 1 and 0.
// The receiver cannot stall; the block takes one command at a time.
// ----------------------------------------------------------------------------
module lcg_jump_and_index_engine #(
  parameter int WIDTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd_i,
  input  logic [lje_pkg::DATA_W-1:0]   seed_i,
  input  logic [lje_pkg::STEPS_W-1:0]  steps_i,
  output logic                         done_o,
  output logic [lje_pkg::DATA_W-1:0]   value_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lje_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [lje_pkg::DATA_W-1:0]   cfg_data_i
);

  logic [WIDTH-1:0] mult_q, inc_q, imult_q, iinc_q;
  logic             accept;
  logic             cfg_we;
  lje_pkg::ctl_t    ctl;
  lje_pkg::stat_t   stat;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q  <= WIDTH'(1);
      inc_q   <= '0;
      imult_q <= WIDTH'(1);
      iinc_q  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr_i)
        lje_pkg::REG_MULT:  mult_q  <= cfg_data_i[WIDTH-1:0];
        lje_pkg::REG_INC:   inc_q   <= cfg_data_i[WIDTH-1:0];
        lje_pkg::REG_IMULT: imult_q <= cfg_data_i[WIDTH-1:0];
        lje_pkg::REG_IINC:  iinc_q  <= cfg_data_i[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  lje_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  lje_dp #(.WIDTH(WIDTH)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .cmd_i   (cmd_i),
    .seed_i  (seed_i[WIDTH-1:0]),
    .steps_i (steps_i),
    .mult_i  (mult_q),
    .inc_i   (inc_q),
    .imult_i (imult_q),
    .iinc_i  (iinc_q),
    .ctl_i   (ctl),
    .stat_o  (stat),
    .done_o  (done_o),
    .value_o (value_o)
  );

  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted command did not start");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((value_o >> WIDTH) == '0))
    else $error("result exceeds WIDTH bits");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LCG jump-ahead and index engine: commands go
// in through the start/busy handshake in random bursts, every result word is
// checked against a bit-exact predictor across a series of generator
// settings, including the register extremes and inconsistent inverses.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] LCG64_MULT = 64'h5D588B656C078965;
  localparam logic [63:0] LCG64_INC  = 64'h0000000000269EC3;
  localparam logic [63:0] LCG32_MULT = 64'h0000000041C64E6D;
  localparam logic [63:0] LCG32_INC  = 64'h0000000000006073;
  localparam logic [63:0] ALL_ONES   = {64{1'b1}};
  localparam int RAND_PER_SETTING = 160;
  localparam int IDLE_LIMIT       = 10000;
  localparam int TAIL_CYCLES      = 1000;

  typedef struct packed {
    lje_pkg::cmd_e cmd;
    logic [63:0]   seed;
    logic [63:0]   steps;
  } cmd_word_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // DUT connections
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 cmd = lje_pkg::CMD_FWD;
  logic [63:0]                seed = '0;
  logic [63:0]                steps = '0;
  logic                       done;
  logic [63:0]                value;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [lje_pkg::CFG_AW-1:0] cfg_addr = lje_pkg::REG_MULT;
  logic [63:0]                cfg_data = '0;

  lcg_jump_and_index_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .seed_i      (seed),
    .steps_i     (steps),
    .done_o      (done),
    .value_o     (value),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  // command words waiting to go out, and result values still owed
  cmd_word_t   cmd_backlog[$];
  logic [63:0] pending_values[$];
  int          mismatch_count = 0;

  // generator setting as the bench sees it (written by the stimulus)
  logic [63:0] cur_mult, cur_inc;

  // ---------------------------------------------------------------- predictor
  // Affine map x -> m*x + c applied cnt times by repeated squaring
  function automatic logic [63:0] lcg_leap(input logic [63:0] x, input logic [63:0] cnt,
                                           input logic [63:0] m, input logic [63:0] c);
    for (int i = 0; i < 64; i++) begin
      if (cnt[i]) x = x * m + c;
      c = m * c + c;
      m = m * m;
    end
    return x;
  endfunction

  // Step count from state zero to x, one bit settled per round
  function automatic logic [63:0] lcg_index(input logic [63:0] x, input logic [63:0] m,
                                            input logic [63:0] c);
    logic [63:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        n[i] = 1'b1;
        x = x - c;
        c = c * m;
      end
      c = c * (m + 64'd1);
      m = m * m;
    end
    return n;
  endfunction

  // Inverse of an odd multiplier mod 2^64 (Newton, 3 -> 192 good bits)
  function automatic logic [63:0] odd_inverse(input logic [63:0] m);
    logic [63:0] y;
    y = m;
    repeat (6) y = y * (64'd2 - m * y);
    return y;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Jump counts of random bit length, so round counts spread over 1..64
  function automatic logic [63:0] rand_steps();
    int k;
    logic [63:0] s;
    k = $urandom_range(0, 64);
    s = rand64();
    if (k == 64) return s;
    s = s & ((64'd1 << k) - 64'd1);
    if (k != 0 && $urandom_range(0, 1)) s[k-1] = 1'b1;
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- driver
  cmd_word_t next_word;
  int        burst_left;
  int        gap_left;

  // present a new word once the current one is taken or the line is idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        next_word = cmd_backlog.pop_front();
        start <= 1'b1;
        cmd   <= next_word.cmd;
        seed  <= next_word.seed;
        steps <= next_word.steps;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 1200)
                                                 : $urandom_range(0, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  logic [63:0] mult_q, inc_q, imult_q, iinc_q;
  logic [63:0] expected_value;
  int          idle_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q = 64'd1;
      inc_q = '0;
      imult_q = 64'd1;
      iinc_q = '0;
      idle_cycles = 0;
    end else begin
      // register writes; indexes past the last register are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          lje_pkg::REG_MULT:  mult_q = cfg_data;
          lje_pkg::REG_INC:   inc_q = cfg_data;
          lje_pkg::REG_IMULT: imult_q = cfg_data;
          lje_pkg::REG_IINC:  iinc_q = cfg_data;
          default:            ;
        endcase
      end

      // accepted command word: predict its result
      if (start && !busy) begin
        case (lje_pkg::cmd_e'(cmd))
          lje_pkg::CMD_FWD: expected_value = lcg_leap(seed, steps, mult_q, inc_q);
          lje_pkg::CMD_BWD: expected_value = lcg_leap(seed, steps, imult_q, iinc_q);
          lje_pkg::CMD_IDX: expected_value = lcg_index(seed, mult_q, inc_q);
          default:          expected_value = seed;
        endcase
        pending_values.push_back(expected_value);
      end

      // result word against the oldest prediction
      if (done) begin
        if (pending_values.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", value));
        end else begin
          expected_value = pending_values.pop_front();
          if (value !== expected_value)
            report_mismatch($sformatf("value %h, expected %h", value, expected_value));
        end
      end

      // watchdog on cycles with no word moving anywhere
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_cmd(input lje_pkg::cmd_e c, input logic [63:0] s,
                         input logic [63:0] n);
    cmd_word_t w;
    w.cmd = c;
    w.seed = s;
    w.steps = n;
    cmd_backlog.push_back(w);
  endtask

  // wait until every queued word went out and every result came back
  task automatic settle();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start || pending_values.size() != 0);
  endtask

  task automatic write_reg(input logic [lje_pkg::CFG_AW-1:0] idx,
                           input logic [63:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= data;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // full register load; sometimes a stray write past the last index too
  task automatic load_lcg(input logic [63:0] m, input logic [63:0] c,
                          input logic [63:0] im, input logic [63:0] ic);
    cur_mult = m;
    cur_inc = c;
    write_reg(lje_pkg::REG_MULT, m);
    write_reg(lje_pkg::REG_INC, c);
    write_reg(lje_pkg::REG_IMULT, im);
    write_reg(lje_pkg::REG_IINC, ic);
    if ($urandom_range(0, 1))
      write_reg(lje_pkg::REG_IINC + lje_pkg::CFG_AW'($urandom_range(1, 12)), rand64());
    @(negedge clk_i);
  endtask

  task automatic load_consistent(input logic [63:0] m, input logic [63:0] c);
    logic [63:0] im;
    im = odd_inverse(m);
    load_lcg(m, c, im, 64'd0 - im * c);
  endtask

  // random words: mostly round trips and indexes of reachable states
  task automatic fill_random(input int count);
    int queued;
    int sel;
    logic [63:0] x, n, y;
    queued = 0;
    while (queued < count) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        x = rand64();
        n = rand_steps();
        y = lcg_leap(x, n, cur_mult, cur_inc);
        add_cmd(lje_pkg::CMD_FWD, x, n);
        add_cmd(lje_pkg::CMD_BWD, y, n);
        add_cmd(lje_pkg::CMD_IDX, lcg_leap(64'd0, n, cur_mult, cur_inc), rand64());
        queued += 3;
      end else begin
        case (sel)
          4, 5:    add_cmd(lje_pkg::CMD_FWD, rand64(), rand_steps());
          6, 7:    add_cmd(lje_pkg::CMD_BWD, rand64(), rand_steps());
          8:       add_cmd(lje_pkg::CMD_IDX, rand64(), rand64());
          default: add_cmd(lje_pkg::CMD_PASS, rand64(), rand64());
        endcase
        queued++;
      end
      // now and then hold off until the engine has drained
      if ($urandom_range(0, 39) == 0) settle();
    end
    settle();
  endtask

  initial begin
    logic [63:0] x, n, y;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at their reset values
    cur_mult = 64'd1;
    cur_inc = '0;
    add_cmd(lje_pkg::CMD_FWD, rand64(), rand64());
    add_cmd(lje_pkg::CMD_BWD, rand64(), rand64());
    add_cmd(lje_pkg::CMD_IDX, rand64(), '0);
    add_cmd(lje_pkg::CMD_PASS, ALL_ONES, '0);
    settle();

    // directed words on the 64-bit generator
    load_consistent(LCG64_MULT, LCG64_INC);
    add_cmd(lje_pkg::CMD_FWD, '0, '0);
    add_cmd(lje_pkg::CMD_FWD, ALL_ONES, '0);
    add_cmd(lje_pkg::CMD_FWD, '0, 64'd1);
    add_cmd(lje_pkg::CMD_FWD, ALL_ONES, 64'd1);
    add_cmd(lje_pkg::CMD_FWD, rand64(), ALL_ONES);
    add_cmd(lje_pkg::CMD_FWD, rand64(), 64'h8000000000000000);
    add_cmd(lje_pkg::CMD_BWD, '0, 64'd1);
    add_cmd(lje_pkg::CMD_BWD, ALL_ONES, ALL_ONES);
    add_cmd(lje_pkg::CMD_BWD, rand64(), '0);
    add_cmd(lje_pkg::CMD_BWD, rand64(), 64'h8000000000000000);
    add_cmd(lje_pkg::CMD_IDX, '0, ALL_ONES);
    add_cmd(lje_pkg::CMD_IDX, ALL_ONES, '0);
    add_cmd(lje_pkg::CMD_IDX, 64'd1, '0);
    add_cmd(lje_pkg::CMD_PASS, ALL_ONES, rand64());
    add_cmd(lje_pkg::CMD_PASS, '0, ALL_ONES);
    // forward then back by the same count, and the index of a known state
    x = rand64();
    n = rand64();
    y = lcg_leap(x, n, cur_mult, cur_inc);
    add_cmd(lje_pkg::CMD_FWD, x, n);
    add_cmd(lje_pkg::CMD_BWD, y, n);
    add_cmd(lje_pkg::CMD_IDX, lcg_leap(64'd0, n, cur_mult, cur_inc), '0);
    add_cmd(lje_pkg::CMD_IDX, lcg_leap(64'd0, ALL_ONES, cur_mult, cur_inc), '0);
    settle();

    // random words across a range of generator settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: load_consistent(LCG64_MULT, LCG64_INC);
        1: load_consistent(LCG32_MULT, LCG32_INC);
        2: load_consistent(ALL_ONES, ALL_ONES);
        3: load_lcg('0, '0, '0, '0);
        4: load_consistent(rand64() | 64'd1, rand64());
        5: load_lcg(rand64() & ~64'd1, rand64(), rand64(), rand64());
        6: load_consistent(rand64() | 64'd1, rand64() & ~64'd1);
        default: load_consistent(64'd1, ALL_ONES);
      endcase
      fill_random(RAND_PER_SETTING);
    end

    // let any late strobe show up before closing
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_values.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_values.size()));
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lje_pkg.sv
rtl/lje_mul.sv
rtl/lje_seq.sv
rtl/lje_dp.sv
rtl/lcg_jump_and_index_engine.sv
test/testbench.sv
